### hw/rtl/ocd_pkg.sv
// ----------------------------------------------------------------------------
// ocd_pkg: shared types and constants of the OLED command decoder
// Opcodes, addressing modes, the decoded operation passed from the front
// part to the back part, and address arithmetic widths.
// ----------------------------------------------------------------------------
package ocd_pkg;

	// Bytes per page row of display memory
	localparam int PAGE_WIDTH = 128;

	// Memory sizes for the two panel heights
	localparam int MEM_SIZE_TALL  = 1024;
	localparam int MEM_SIZE_SHORT = 512;

	localparam int POS_W  = 10;
	localparam int ADDR_W = 10;
	// Width of page * PAGE_WIDTH + column + position before the range check
	localparam int CALC_W = $clog2(7 * PAGE_WIDTH + 255 + PAGE_WIDTH + 1);

	// Control byte classes
	localparam logic [7:0] CTL_COMMAND   = 8'h00;
	localparam logic [7:0] CTL_DATA_BASE = 8'h40;

	// Command byte ranges
	localparam logic [7:0] CMD_COL_LOW_HI   = 8'h0F;
	localparam logic [7:0] CMD_COL_HIGH_HI  = 8'h1F;
	localparam logic [7:0] CMD_LINE_LO      = 8'h40;
	localparam logic [7:0] CMD_LINE_HI      = 8'h7F;
	localparam logic [7:0] CMD_PAGE_LO      = 8'hB0;
	localparam logic [7:0] CMD_PAGE_HI      = 8'hB7;

	// Commands with arguments
	localparam logic [7:0] CMD_ADDR_MODE    = 8'h20;
	localparam logic [7:0] CMD_COL_RANGE    = 8'h21;
	localparam logic [7:0] CMD_PAGE_RANGE   = 8'h22;
	localparam logic [7:0] CMD_CONTRAST     = 8'h81;
	localparam logic [7:0] CMD_CHARGE_PUMP  = 8'h8D;
	localparam logic [7:0] CMD_MUX_RATIO    = 8'hA8;
	localparam logic [7:0] CMD_OFFSET       = 8'hD3;
	localparam logic [7:0] CMD_CLOCK_DIV    = 8'hD5;
	localparam logic [7:0] CMD_PRECHARGE    = 8'hD9;
	localparam logic [7:0] CMD_COM_PINS     = 8'hDA;
	localparam logic [7:0] CMD_VCOM_DESEL   = 8'hDB;

	// Single-byte flag commands
	localparam logic [7:0] CMD_DISPLAY_OFF  = 8'hAE;
	localparam logic [7:0] CMD_DISPLAY_ON   = 8'hAF;
	localparam logic [7:0] CMD_SCAN_REV     = 8'hC0;
	localparam logic [7:0] CMD_SCAN_NORM    = 8'hC8;
	localparam logic [7:0] CMD_SEG_REMAP    = 8'hA0;
	localparam logic [7:0] CMD_SEG_NORM     = 8'hA1;
	localparam logic [7:0] CMD_INV_OFF      = 8'hA6;
	localparam logic [7:0] CMD_INV_ON       = 8'hA7;

	// Addressing modes
	localparam logic [7:0] MODE_HORIZONTAL  = 8'h00;
	localparam logic [7:0] MODE_PAGE        = 8'h02;

	localparam logic [7:0] CONTRAST_RESET   = 8'h7F;

	typedef enum logic [3:0] {
		OP_NONE       = 4'd0,
		OP_FIRST_LINE = 4'd1,
		OP_COL_LOW    = 4'd2,
		OP_COL_HIGH   = 4'd3,
		OP_PAGE       = 4'd4,
		OP_FLAG_ON    = 4'd5,
		OP_FLAG_MX    = 4'd6,
		OP_FLAG_MY    = 4'd7,
		OP_FLAG_INV   = 4'd8,
		OP_MODE       = 4'd9,
		OP_CONTRAST   = 4'd10,
		OP_OFFSET     = 4'd11,
		OP_DATA       = 4'd12
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] value;
		logic       first;
	} op_t;

endpackage

### hw/rtl/ocd_if.sv
// ----------------------------------------------------------------------------
// ocd_in_if / ocd_out_if: bus byte and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ocd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] bus_byte;
	logic [7:0] control_byte;
	logic       first_of_transfer;

	modport source (output valid, output bus_byte, output control_byte,
		output first_of_transfer, input ready);
	modport sink (input valid, input bus_byte, input control_byte,
		input first_of_transfer, output ready);
endinterface

interface ocd_out_if;
	logic       valid;
	logic       ready;
	logic       mem_write;
	logic [9:0] byte_addr;
	logic [7:0] mem_data;
	logic       panel_on;
	logic       mirror_x;
	logic       mirror_y;
	logic       invert_pixels;
	logic [7:0] contrast_level;
	logic [8:0] row_shift;

	modport source (output valid, output mem_write, output byte_addr, output mem_data,
		output panel_on, output mirror_x, output mirror_y, output invert_pixels,
		output contrast_level, output row_shift, input ready);
	modport sink (input valid, input mem_write, input byte_addr, input mem_data,
		input panel_on, input mirror_x, input mirror_y, input invert_pixels,
		input contrast_level, input row_shift, output ready);
endinterface

### hw/rtl/ocd_front.sv
// ----------------------------------------------------------------------------
// ocd_front: byte classifier
// Tracks pending command arguments and turns each accepted bus byte into
// one decoded operation.
// ----------------------------------------------------------------------------
module ocd_front (
	input  logic          clk,
	input  logic          arst_n,
	ocd_in_if.sink        in_ch,
	output logic          op_valid,
	output ocd_pkg::op_t  op,
	input  logic          op_ready
);

	logic [7:0] pending_opcode_q;
	logic [1:0] args_left_q;
	logic [7:0] pending_next;
	logic [1:0] args_next;
	logic       accept;
	logic [7:0] b;

	assign in_ch.ready = op_ready;
	assign op_valid    = in_ch.valid;
	assign accept      = in_ch.valid && op_ready;
	assign b           = in_ch.bus_byte;

	always_comb begin
		pending_next = pending_opcode_q;
		args_next    = args_left_q;
		op.kind      = ocd_pkg::OP_NONE;
		op.value     = b;
		op.first     = in_ch.first_of_transfer;
		if (in_ch.control_byte == ocd_pkg::CTL_COMMAND) begin
			if (args_left_q != 2'd0) begin
				args_next = args_left_q - 2'd1;
				case (pending_opcode_q)
					ocd_pkg::CMD_ADDR_MODE: op.kind = ocd_pkg::OP_MODE;
					ocd_pkg::CMD_CONTRAST:  op.kind = ocd_pkg::OP_CONTRAST;
					ocd_pkg::CMD_OFFSET:    op.kind = ocd_pkg::OP_OFFSET;
					default:                op.kind = ocd_pkg::OP_NONE;
				endcase
			end else if (b inside {[ocd_pkg::CMD_LINE_LO:ocd_pkg::CMD_LINE_HI]}) begin
				op.kind = ocd_pkg::OP_FIRST_LINE;
			end else if (b <= ocd_pkg::CMD_COL_LOW_HI) begin
				op.kind = ocd_pkg::OP_COL_LOW;
			end else if (b <= ocd_pkg::CMD_COL_HIGH_HI) begin
				op.kind = ocd_pkg::OP_COL_HIGH;
			end else if (b inside {[ocd_pkg::CMD_PAGE_LO:ocd_pkg::CMD_PAGE_HI]}) begin
				op.kind = ocd_pkg::OP_PAGE;
			end else if (b inside {ocd_pkg::CMD_COL_RANGE, ocd_pkg::CMD_PAGE_RANGE}) begin
				pending_next = b;
				args_next    = 2'd2;
			end else if (b inside {ocd_pkg::CMD_ADDR_MODE, ocd_pkg::CMD_CONTRAST,
					ocd_pkg::CMD_MUX_RATIO, ocd_pkg::CMD_OFFSET, ocd_pkg::CMD_CLOCK_DIV,
					ocd_pkg::CMD_PRECHARGE, ocd_pkg::CMD_COM_PINS,
					ocd_pkg::CMD_VCOM_DESEL, ocd_pkg::CMD_CHARGE_PUMP}) begin
				pending_next = b;
				args_next    = 2'd1;
			end else begin
				// Flag commands carry the new flag value in value[0]
				case (b)
					ocd_pkg::CMD_DISPLAY_OFF: begin
						op.kind = ocd_pkg::OP_FLAG_ON;  op.value = 8'd0;
					end
					ocd_pkg::CMD_DISPLAY_ON: begin
						op.kind = ocd_pkg::OP_FLAG_ON;  op.value = 8'd1;
					end
					ocd_pkg::CMD_SCAN_REV: begin
						op.kind = ocd_pkg::OP_FLAG_MY;  op.value = 8'd1;
					end
					ocd_pkg::CMD_SCAN_NORM: begin
						op.kind = ocd_pkg::OP_FLAG_MY;  op.value = 8'd0;
					end
					ocd_pkg::CMD_SEG_REMAP: begin
						op.kind = ocd_pkg::OP_FLAG_MX;  op.value = 8'd1;
					end
					ocd_pkg::CMD_SEG_NORM: begin
						op.kind = ocd_pkg::OP_FLAG_MX;  op.value = 8'd0;
					end
					ocd_pkg::CMD_INV_OFF: begin
						op.kind = ocd_pkg::OP_FLAG_INV; op.value = 8'd0;
					end
					ocd_pkg::CMD_INV_ON: begin
						op.kind = ocd_pkg::OP_FLAG_INV; op.value = 8'd1;
					end
					default: op.kind = ocd_pkg::OP_NONE;
				endcase
			end
		end else if (in_ch.control_byte >= ocd_pkg::CTL_DATA_BASE) begin
			op.kind = ocd_pkg::OP_DATA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_opcode_q <= 8'd0;
			args_left_q      <= 2'd0;
		end else if (accept) begin
			pending_opcode_q <= pending_next;
			args_left_q      <= args_next;
		end
	end

endmodule

### hw/rtl/ocd_queue.sv
// ----------------------------------------------------------------------------
// ocd_queue: two-entry operation queue
// Decouples the classifier from the executor.
// ----------------------------------------------------------------------------
module ocd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  ocd_pkg::op_t  push_op,
	output logic          push_ready,
	output logic          pop_valid,
	output ocd_pkg::op_t  pop_op,
	input  logic          pop_ready
);

	ocd_pkg::op_t entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         push;
	logic         pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_op     = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hw/rtl/ocd_back.sv
// ----------------------------------------------------------------------------
// ocd_back: operation executor
// Holds the display registers and data position, forms memory writes and
// drives the registered result.
// ----------------------------------------------------------------------------
module ocd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tall_panel,
	input  logic          op_valid,
	input  ocd_pkg::op_t  op,
	output logic          op_ready,
	ocd_out_if.source     out_ch
);

	localparam int CW = ocd_pkg::CALC_W;

	logic [7:0]                addressing_mode_q;
	logic [2:0]                page_number_q;
	logic [3:0]                column_low_q;
	logic [3:0]                column_high_q;
	logic [5:0]                first_line_q;
	logic [7:0]                offset_setting_q;
	logic [ocd_pkg::POS_W-1:0] data_position_q;
	logic                      flag_on_q;
	logic                      flag_mx_q;
	logic                      flag_my_q;
	logic                      flag_inv_q;
	logic [7:0]                contrast_q;
	logic                      out_valid_q;

	logic                      pop;
	logic [ocd_pkg::POS_W-1:0] pos_base;
	logic [ocd_pkg::POS_W-1:0] pos_next;
	logic [CW-1:0]             mem_size;
	logic [CW-1:0]             page_addr;
	logic                      wr;
	logic [ocd_pkg::ADDR_W-1:0] addr;
	logic [7:0]                line_next;
	logic [7:0]                offset_next;

	assign op_ready = !out_valid_q || out_ch.ready;
	assign pop      = op_valid && op_ready;
	assign mem_size = tall_panel ? CW'(ocd_pkg::MEM_SIZE_TALL) : CW'(ocd_pkg::MEM_SIZE_SHORT);
	assign pos_base = op.first ? '0 : data_position_q;
	assign page_addr = CW'(page_number_q) * CW'(ocd_pkg::PAGE_WIDTH)
		+ CW'({column_high_q, column_low_q}) + CW'(pos_base);

	always_comb begin
		wr       = 1'b0;
		addr     = '0;
		pos_next = pos_base;
		if (op.kind == ocd_pkg::OP_DATA) begin
			if (addressing_mode_q == ocd_pkg::MODE_HORIZONTAL) begin
				wr       = 1'b1;
				addr     = pos_base & ocd_pkg::ADDR_W'(mem_size - CW'(1));
				pos_next = pos_base + ocd_pkg::POS_W'(1);
			end else if (addressing_mode_q == ocd_pkg::MODE_PAGE) begin
				if (pos_base < ocd_pkg::POS_W'(ocd_pkg::PAGE_WIDTH)) begin
					// Clip writes that run past the end of memory
					if (page_addr < mem_size) begin
						wr   = 1'b1;
						addr = page_addr[ocd_pkg::ADDR_W-1:0];
					end
					pos_next = pos_base + ocd_pkg::POS_W'(1);
				end
			end
		end
	end

	assign line_next   = (op.kind == ocd_pkg::OP_FIRST_LINE) ? {2'b00, op.value[5:0]}
		: {2'b00, first_line_q};
	assign offset_next = (op.kind == ocd_pkg::OP_OFFSET) ? op.value : offset_setting_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addressing_mode_q <= ocd_pkg::MODE_HORIZONTAL;
			page_number_q     <= 3'd0;
			column_low_q      <= 4'd0;
			column_high_q     <= 4'd0;
			first_line_q      <= 6'd0;
			offset_setting_q  <= 8'd0;
			data_position_q   <= '0;
			flag_on_q         <= 1'b1;
			flag_mx_q         <= 1'b0;
			flag_my_q         <= 1'b0;
			flag_inv_q        <= 1'b0;
			contrast_q        <= ocd_pkg::CONTRAST_RESET;
			out_valid_q       <= 1'b0;
		end else begin
			if (pop) begin
				data_position_q <= pos_next;
				first_line_q    <= line_next[5:0];
				offset_setting_q <= offset_next;
				case (op.kind)
					ocd_pkg::OP_COL_LOW:  column_low_q      <= op.value[3:0];
					ocd_pkg::OP_COL_HIGH: column_high_q     <= op.value[3:0];
					ocd_pkg::OP_PAGE:     page_number_q     <= op.value[2:0];
					ocd_pkg::OP_FLAG_ON:  flag_on_q         <= op.value[0];
					ocd_pkg::OP_FLAG_MX:  flag_mx_q         <= op.value[0];
					ocd_pkg::OP_FLAG_MY:  flag_my_q         <= op.value[0];
					ocd_pkg::OP_FLAG_INV: flag_inv_q        <= op.value[0];
					ocd_pkg::OP_MODE:     addressing_mode_q <= op.value;
					ocd_pkg::OP_CONTRAST: contrast_q        <= op.value;
					default:              ;
				endcase
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: loaded with the state as it stands after the operation
	always_ff @(posedge clk) begin
		if (pop) begin
			out_ch.mem_write      <= wr;
			out_ch.byte_addr      <= addr;
			out_ch.mem_data       <= wr ? op.value : 8'd0;
			out_ch.panel_on       <= (op.kind == ocd_pkg::OP_FLAG_ON)  ? op.value[0] : flag_on_q;
			out_ch.mirror_x       <= (op.kind == ocd_pkg::OP_FLAG_MX)  ? op.value[0] : flag_mx_q;
			out_ch.mirror_y       <= (op.kind == ocd_pkg::OP_FLAG_MY)  ? op.value[0] : flag_my_q;
			out_ch.invert_pixels  <= (op.kind == ocd_pkg::OP_FLAG_INV) ? op.value[0] : flag_inv_q;
			out_ch.contrast_level <= (op.kind == ocd_pkg::OP_CONTRAST) ? op.value : contrast_q;
			out_ch.row_shift      <= {1'b0, offset_next} + {1'b0, line_next};
		end
	end

	assign out_ch.valid = out_valid_q;

endmodule

### hw/rtl/oled_command_decoder.sv
// ----------------------------------------------------------------------------
// oled_command_decoder: OLED controller bus byte decoder
// Classifies controller bus bytes as commands, arguments or pixel data,
// keeps the display registers and emits one result per byte with the
// display-memory write it causes.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                       Beat
//  --------  ---  --------------------------------------------  ----------------
//  in_ch     in   bus_byte, control_byte, first_of_transfer     one bus byte
//  out_ch    out  mem_write/addr/data, flags, contrast, shift   one result
//  cfg       in   cfg_wdata = tall_panel (cfg_we strobe)        register write
//
//  One byte enters per cycle while the queue has room; each result is registered
//  twice after its byte (classifier into the queue, executor into the output register).
//  The queue holds two decoded operations; in_ch.ready drops only when it is
//  full, so a stalled output side backs up through the queue.
//  Reset is asynchronous and active low; it restores panel on, contrast 127,
//  horizontal mode and a 128x64 panel.
//
module oled_command_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	ocd_in_if.sink     in_ch,
	ocd_out_if.source  out_ch
);

	logic         tall_panel_q;
	logic         op_valid;
	ocd_pkg::op_t op;
	logic         op_ready;
	logic         q_valid;
	ocd_pkg::op_t q_op;
	logic         q_ready;

	// Hold the panel height; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tall_panel_q <= 1'b1;
		end else if (cfg_we) begin
			tall_panel_q <= cfg_wdata;
		end
	end

	// Classify: track pending arguments and decode each byte
	ocd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.op_valid (op_valid),
		.op       (op),
		.op_ready (op_ready)
	);

	// Decouple the two sides
	ocd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (op_valid),
		.push_op    (op),
		.push_ready (op_ready),
		.pop_valid  (q_valid),
		.pop_op     (q_op),
		.pop_ready  (q_ready)
	);

	// Execute: advance display state and form memory writes
	ocd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tall_panel (tall_panel_q),
		.op_valid   (q_valid),
		.op         (q_op),
		.op_ready   (q_ready),
		.out_ch     (out_ch)
	);

endmodule

### tb/oled_command_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oled_command_decoder_test: self-checking bench for the OLED command decoder
// Drives bus bytes through the input channel, predicts every result beat from
// a behavioral copy of the decoder state and compares each output beat field
// by field. Covers all commands, argument handling, both addressing modes and
// both panel heights, with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module oled_command_decoder_test;

	localparam int CYCLE_LIMIT = 500000;
	localparam int REPORT_LIMIT = 10;
	localparam int DRAIN_CYCLES = 4;

	// Codes the package does not name
	localparam logic [7:0] MODE_VERTICAL   = 8'h01;
	localparam logic [7:0] CTL_IGNORED_LO  = 8'h01;
	localparam logic [7:0] CTL_IGNORED_HI  = 8'h3F;
	localparam logic [7:0] CTL_DATA_TOP    = 8'hFF;
	localparam logic [7:0] CMD_COL_LOW_LO  = 8'h00;
	localparam logic [7:0] CMD_COL_HIGH_LO = 8'h10;
	localparam logic [7:0] CMD_UNKNOWN     = 8'hE3;

	typedef struct packed {
		logic       mem_write;
		logic [9:0] byte_addr;
		logic [7:0] mem_data;
		logic       panel_on;
		logic       mirror_x;
		logic       mirror_y;
		logic       invert_pixels;
		logic [7:0] contrast_level;
		logic [8:0] row_shift;
	} panel_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b1;

	ocd_in_if  in_ch();
	ocd_out_if out_ch();

	oled_command_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the decoder registers, at their reset values
	logic       tall_sel = 1'b1;
	logic [7:0] pend_op = 8'h00;
	logic [1:0] args_rem = 2'd0;
	logic [7:0] mode_sel = ocd_pkg::MODE_HORIZONTAL;
	logic [2:0] page_sel = 3'd0;
	logic [3:0] col_lo = 4'd0;
	logic [3:0] col_hi = 4'd0;
	logic [5:0] line_sel = 6'd0;
	logic [7:0] disp_offset = 8'h00;
	logic [9:0] write_pos = 10'd0;
	logic       on_f = 1'b1;
	logic       mx_f = 1'b0;
	logic       my_f = 1'b0;
	logic       inv_f = 1'b0;
	logic [7:0] contrast_val = ocd_pkg::CONTRAST_RESET;

	panel_result_t predicted_results[$];
	int mismatch_count = 0;
	int beats_sent = 0;
	int cycle_count = 0;
	bit idle_on = 1'b1;
	int stall_left = 0;

	// Apply one bus byte to the shadow registers and return the result beat
	function automatic panel_result_t decode_bus_byte(input logic [7:0] bus,
		input logic [7:0] ctl, input logic first);
		panel_result_t res;
		int mem_bytes;
		int page_addr;
		res = '0;
		mem_bytes = tall_sel ? ocd_pkg::MEM_SIZE_TALL : ocd_pkg::MEM_SIZE_SHORT;
		if (first)
			write_pos = '0;
		if (ctl == ocd_pkg::CTL_COMMAND) begin
			if (args_rem != 2'd0) begin
				case (pend_op)
					ocd_pkg::CMD_ADDR_MODE: mode_sel = bus;
					ocd_pkg::CMD_CONTRAST:  contrast_val = bus;
					ocd_pkg::CMD_OFFSET:    disp_offset = bus;
					default: ;
				endcase
				args_rem = args_rem - 2'd1;
			end else if (bus >= ocd_pkg::CMD_LINE_LO && bus <= ocd_pkg::CMD_LINE_HI) begin
				line_sel = bus[5:0];
			end else if (bus <= ocd_pkg::CMD_COL_LOW_HI) begin
				col_lo = bus[3:0];
			end else if (bus <= ocd_pkg::CMD_COL_HIGH_HI) begin
				col_hi = bus[3:0];
			end else if (bus >= ocd_pkg::CMD_PAGE_LO && bus <= ocd_pkg::CMD_PAGE_HI) begin
				page_sel = bus[2:0];
			end else begin
				case (bus)
					ocd_pkg::CMD_COL_RANGE, ocd_pkg::CMD_PAGE_RANGE: begin
						pend_op = bus;
						args_rem = 2'd2;
					end
					ocd_pkg::CMD_ADDR_MODE, ocd_pkg::CMD_CONTRAST, ocd_pkg::CMD_MUX_RATIO,
					ocd_pkg::CMD_OFFSET, ocd_pkg::CMD_CLOCK_DIV, ocd_pkg::CMD_PRECHARGE,
					ocd_pkg::CMD_COM_PINS, ocd_pkg::CMD_VCOM_DESEL,
					ocd_pkg::CMD_CHARGE_PUMP: begin
						pend_op = bus;
						args_rem = 2'd1;
					end
					ocd_pkg::CMD_DISPLAY_OFF: on_f = 1'b0;
					ocd_pkg::CMD_DISPLAY_ON:  on_f = 1'b1;
					ocd_pkg::CMD_SCAN_REV:    my_f = 1'b1;
					ocd_pkg::CMD_SCAN_NORM:   my_f = 1'b0;
					ocd_pkg::CMD_SEG_REMAP:   mx_f = 1'b1;
					ocd_pkg::CMD_SEG_NORM:    mx_f = 1'b0;
					ocd_pkg::CMD_INV_OFF:     inv_f = 1'b0;
					ocd_pkg::CMD_INV_ON:      inv_f = 1'b1;
					default: ;
				endcase
			end
		end else if (ctl >= ocd_pkg::CTL_DATA_BASE) begin
			if (mode_sel == ocd_pkg::MODE_HORIZONTAL) begin
				res.mem_write = 1'b1;
				res.byte_addr = write_pos & 10'(mem_bytes - 1);
				res.mem_data = bus;
				write_pos = write_pos + 10'd1;
			end else if (mode_sel == ocd_pkg::MODE_PAGE && write_pos < ocd_pkg::PAGE_WIDTH)
			begin
				// clip at the end of memory, but the position still advances
				page_addr = int'(page_sel) * ocd_pkg::PAGE_WIDTH + int'({col_hi, col_lo})
					+ int'(write_pos);
				if (page_addr < mem_bytes) begin
					res.mem_write = 1'b1;
					res.byte_addr = page_addr[9:0];
					res.mem_data = bus;
				end
				write_pos = write_pos + 10'd1;
			end
		end
		res.panel_on = on_f;
		res.mirror_x = mx_f;
		res.mirror_y = my_f;
		res.invert_pixels = inv_f;
		res.contrast_level = contrast_val;
		res.row_shift = {1'b0, disp_offset} + {3'b000, line_sel};
		return res;
	endfunction

	function automatic string format_result(input panel_result_t r);
		return $sformatf({"wr=%0d addr=%0d data=%02h on=%0d mx=%0d my=%0d",
			" inv=%0d con=%0d shift=%0d"},
			r.mem_write, r.byte_addr, r.mem_data, r.panel_on, r.mirror_x,
			r.mirror_y, r.invert_pixels, r.contrast_level, r.row_shift);
	endfunction

	// Predict on each input beat, then check each output beat against the oldest
	// prediction. Input first, so a beat accepted on this edge is already queued.
	always @(posedge clk) begin : check_results
		panel_result_t want;
		panel_result_t got;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				predicted_results.push_back(decode_bus_byte(in_ch.bus_byte,
					in_ch.control_byte, in_ch.first_of_transfer));
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.mem_write, out_ch.byte_addr, out_ch.mem_data,
					out_ch.panel_on, out_ch.mirror_x, out_ch.mirror_y,
					out_ch.invert_pixels, out_ch.contrast_level, out_ch.row_shift};
				if (predicted_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("[%0t] unexpected result beat: %s", $realtime,
							format_result(got));
				end else begin
					want = predicted_results.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("[%0t] result mismatch\n  expected %s\n  actual   %s",
								$realtime, format_result(want), format_result(got));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("oled_command_decoder_test: done, errors");
			$finish;
		end
	end

	// Sink side: stall in random bursts while idling is on
	always @(negedge clk) begin
		if (!idle_on) begin
			stall_left = 0;
			out_ch.ready = 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ch.ready = 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 12) - 1;
			out_ch.ready = 1'b0;
		end else begin
			out_ch.ready = 1'b1;
		end
	end

	// Present one beat at a falling edge and hold it until accepted.
	// Valid stays high afterwards; the next call or a drain moves it.
	task automatic send_beat(input logic [7:0] bus, input logic [7:0] ctl,
		input logic first);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.bus_byte = bus;
		in_ch.control_byte = ctl;
		in_ch.first_of_transfer = first;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		beats_sent++;
	endtask

	task automatic send_command(input logic [7:0] bus, input logic first);
		send_beat(bus, ocd_pkg::CTL_COMMAND, first);
	endtask

	// Hold off until every predicted result has come back
	task automatic wait_for_drain();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (predicted_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_panel(input logic tall);
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = tall;
		@(negedge clk);
		cfg_we = 1'b0;
		tall_sel = tall;
	endtask

	// Argument byte of a pending command; now and then an ignored beat slips
	// in first, or the argument is dropped so the next command byte eats it.
	task automatic send_argument(input logic [7:0] value);
		if ($urandom_range(0, 15) == 0)
			return;
		if ($urandom_range(0, 9) == 0)
			send_beat(8'($urandom_range(0, 255)),
				8'($urandom_range(CTL_IGNORED_LO, CTL_IGNORED_HI)),
				1'($urandom_range(0, 1)));
		send_command(value, 1'b0);
	endtask

	task automatic send_random_command(input logic first);
		logic [7:0] opcode;
		logic [7:0] arg;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 7))
					0: opcode = ocd_pkg::CMD_DISPLAY_OFF;
					1: opcode = ocd_pkg::CMD_DISPLAY_ON;
					2: opcode = ocd_pkg::CMD_SCAN_REV;
					3: opcode = ocd_pkg::CMD_SCAN_NORM;
					4: opcode = ocd_pkg::CMD_SEG_REMAP;
					5: opcode = ocd_pkg::CMD_SEG_NORM;
					6: opcode = ocd_pkg::CMD_INV_OFF;
					default: opcode = ocd_pkg::CMD_INV_ON;
				endcase
				send_command(opcode, first);
			end
			1: begin
				send_command(ocd_pkg::CMD_CONTRAST, first);
				send_argument(8'($urandom_range(0, 255)));
			end
			2: begin
				send_command(ocd_pkg::CMD_OFFSET, first);
				send_argument(8'($urandom_range(0, 255)));
			end
			3: send_command(ocd_pkg::CMD_LINE_LO + 8'($urandom_range(0, 63)), first);
			4: send_command(CMD_COL_LOW_LO + 8'($urandom_range(0, 15)), first);
			5: send_command(CMD_COL_HIGH_LO + 8'($urandom_range(0, 15)), first);
			6: send_command(ocd_pkg::CMD_PAGE_LO + 8'($urandom_range(0, 7)), first);
			7: begin
				// favor the two modes that write, keep vertical and junk rare
				case ($urandom_range(0, 9))
					0, 1, 2, 3: arg = ocd_pkg::MODE_HORIZONTAL;
					4, 5, 6, 7: arg = ocd_pkg::MODE_PAGE;
					8: arg = MODE_VERTICAL;
					default: arg = 8'($urandom_range(0, 255));
				endcase
				send_command(ocd_pkg::CMD_ADDR_MODE, first);
				send_argument(arg);
			end
			8: begin
				case ($urandom_range(0, 7))
					0: opcode = ocd_pkg::CMD_COL_RANGE;
					1: opcode = ocd_pkg::CMD_PAGE_RANGE;
					2: opcode = ocd_pkg::CMD_MUX_RATIO;
					3: opcode = ocd_pkg::CMD_CLOCK_DIV;
					4: opcode = ocd_pkg::CMD_PRECHARGE;
					5: opcode = ocd_pkg::CMD_COM_PINS;
					6: opcode = ocd_pkg::CMD_VCOM_DESEL;
					default: opcode = ocd_pkg::CMD_CHARGE_PUMP;
				endcase
				send_command(opcode, first);
				send_argument(8'($urandom_range(0, 255)));
				if (opcode == ocd_pkg::CMD_COL_RANGE || opcode == ocd_pkg::CMD_PAGE_RANGE)
					send_argument(8'($urandom_range(0, 255)));
			end
			default: send_command(8'($urandom_range(0, 255)), first);
		endcase
	endtask

	task automatic send_data_transfer(input int len);
		logic restart;
		restart = ($urandom_range(0, 7) != 0);
		for (int i = 0; i < len; i++)
			send_beat(8'($urandom_range(0, 255)),
				8'($urandom_range(ocd_pkg::CTL_DATA_BASE, CTL_DATA_TOP)),
				restart && i == 0);
	endtask

	task automatic test_single_commands();
		send_command(ocd_pkg::CMD_DISPLAY_OFF, 1'b1);
		send_command(ocd_pkg::CMD_DISPLAY_ON, 1'b1);
		send_command(ocd_pkg::CMD_SCAN_REV, 1'b1);
		send_command(ocd_pkg::CMD_SCAN_NORM, 1'b1);
		send_command(ocd_pkg::CMD_SEG_REMAP, 1'b1);
		send_command(ocd_pkg::CMD_SEG_NORM, 1'b1);
		send_command(ocd_pkg::CMD_INV_ON, 1'b1);
		send_command(ocd_pkg::CMD_INV_OFF, 1'b1);
		send_command(CMD_UNKNOWN, 1'b1);
	endtask

	task automatic test_argument_commands();
		// the contrast argument survives an ignored beat and a new transfer
		send_command(ocd_pkg::CMD_CONTRAST, 1'b1);
		send_beat(8'hFF, CTL_IGNORED_HI, 1'b1);
		send_command(8'hFF, 1'b1);
		// largest unwrapped row shift
		send_command(ocd_pkg::CMD_OFFSET, 1'b1);
		send_command(8'hFF, 1'b0);
		send_command(ocd_pkg::CMD_LINE_HI, 1'b0);
		// two discarded arguments that look like real commands
		send_command(ocd_pkg::CMD_PAGE_RANGE, 1'b1);
		send_command(ocd_pkg::CMD_DISPLAY_OFF, 1'b0);
		send_command(ocd_pkg::CMD_INV_ON, 1'b0);
	endtask

	task automatic test_page_addressing();
		send_command(ocd_pkg::CMD_ADDR_MODE, 1'b1);
		send_command(ocd_pkg::MODE_PAGE, 1'b0);
		send_command(ocd_pkg::CMD_COL_HIGH_HI, 1'b0);
		send_command(ocd_pkg::CMD_COL_LOW_HI, 1'b0);
		send_command(ocd_pkg::CMD_PAGE_HI, 1'b0);
		// page 7, column 255: past the end of memory, no write
		send_beat(8'hA5, CTL_DATA_TOP, 1'b1);
		send_command(ocd_pkg::CMD_PAGE_LO, 1'b1);
		send_beat(8'h5A, ocd_pkg::CTL_DATA_BASE, 1'b1);
		// vertical mode swallows data
		send_command(ocd_pkg::CMD_ADDR_MODE, 1'b1);
		send_command(MODE_VERTICAL, 1'b0);
		send_beat(8'hFF, ocd_pkg::CTL_DATA_BASE, 1'b1);
		send_beat(8'h00, CTL_IGNORED_LO, 1'b0);
		send_command(ocd_pkg::CMD_ADDR_MODE, 1'b1);
		send_command(ocd_pkg::MODE_HORIZONTAL, 1'b0);
	endtask

	task automatic test_short_panel();
		set_panel(1'b0);
		// horizontal writes wrap at the 512-byte boundary
		for (int i = 0; i < ocd_pkg::MEM_SIZE_SHORT + 8; i++)
			send_beat(8'($urandom_range(0, 255)), ocd_pkg::CTL_DATA_BASE, i == 0);
		send_command(ocd_pkg::CMD_ADDR_MODE, 1'b1);
		send_command(ocd_pkg::MODE_PAGE, 1'b0);
		send_command(ocd_pkg::CMD_PAGE_LO, 1'b0);
		send_command(CMD_COL_HIGH_LO, 1'b0);
		send_command(CMD_COL_LOW_LO, 1'b0);
		// a page transfer stops writing after one page width
		for (int i = 0; i < ocd_pkg::PAGE_WIDTH + 2; i++)
			send_beat(8'($urandom_range(0, 255)), CTL_DATA_TOP, i == 0);
		// last byte of memory, then clipped
		send_command(ocd_pkg::CMD_PAGE_LO + 8'd3, 1'b1);
		send_command(CMD_COL_HIGH_LO + 8'd7, 1'b0);
		send_command(ocd_pkg::CMD_COL_LOW_HI, 1'b0);
		send_beat(8'h81, ocd_pkg::CTL_DATA_BASE, 1'b1);
		send_beat(8'h18, ocd_pkg::CTL_DATA_BASE, 1'b0);
		send_command(ocd_pkg::CMD_PAGE_LO + 8'd4, 1'b1);
		send_beat(8'h3C, ocd_pkg::CTL_DATA_BASE, 1'b1);
		send_command(ocd_pkg::CMD_ADDR_MODE, 1'b1);
		send_command(ocd_pkg::MODE_HORIZONTAL, 1'b0);
	endtask

	// Mostly well-formed command and data transfers with random content,
	// plus raw noise beats and an occasional full drain.
	task automatic test_random_traffic(input int beat_count);
		int stop_at;
		int pick;
		int cmds;
		stop_at = beats_sent + beat_count;
		while (beats_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				send_data_transfer(($urandom_range(0, 9) == 0) ?
					$urandom_range(ocd_pkg::PAGE_WIDTH - 8, ocd_pkg::PAGE_WIDTH + 12)
					: $urandom_range(1, 16));
			end else if (pick < 80) begin
				cmds = $urandom_range(1, 4);
				for (int i = 0; i < cmds; i++)
					send_random_command(i == 0);
			end else if (pick < 96) begin
				send_beat(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end else begin
				wait_for_drain();
			end
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.bus_byte = '0;
		in_ch.control_byte = '0;
		in_ch.first_of_transfer = 1'b0;
		out_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_single_commands();
		test_argument_commands();
		test_page_addressing();
		test_short_panel();
		test_random_traffic(60);
		set_panel(1'b1);
		test_random_traffic(50);
		// last stretch runs at full rate on both sides
		wait_for_drain();
		idle_on = 1'b0;
		test_random_traffic(50);

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("oled_command_decoder_test: done, clean");
		else
			$display("oled_command_decoder_test: done, errors");
		$finish;
	end

endmodule
